// ----- design/sie_pkg.sv -----
// ----------------------------------------------------------------------------
// sie_pkg
// Shared types and constants for the instruction execute block: opcodes,
// instruction classes, the decoded item and the result item.
// ----------------------------------------------------------------------------
package sie_pkg;

	// Opcodes of the machine; codes above OP_LOADI16H are invalid
	typedef enum logic [4:0] {
		OP_ADD      = 5'd0,
		OP_SUB      = 5'd1,
		OP_AND      = 5'd2,
		OP_OR       = 5'd3,
		OP_XOR      = 5'd4,
		OP_NOT      = 5'd5,
		OP_LOAD     = 5'd6,
		OP_STORE    = 5'd7,
		OP_JUMP     = 5'd8,
		OP_BRANCH   = 5'd9,
		OP_CMP      = 5'd10,
		OP_BEQ      = 5'd11,
		OP_BNE      = 5'd12,
		OP_BLT      = 5'd13,
		OP_BGT      = 5'd14,
		OP_LOADI    = 5'd15,
		OP_CALL     = 5'd16,
		OP_LOADI16  = 5'd17,
		OP_LOADI16H = 5'd18
	} op_t;

	// Instruction classes assigned by the front end
	typedef enum logic [2:0] {
		CL_ALU,
		CL_LOAD,
		CL_STORE,
		CL_BRANCH,
		CL_CMP,
		CL_IMM,
		CL_CALL,
		CL_INVALID
	} cls_t;

	localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
	localparam logic [31:0] HI_MASK   = 32'hFFFF_0000;
	localparam logic [31:0] LO_MASK   = 32'h0000_FFFF;
	localparam logic [31:0] PC_STEP   = 32'd4;

	// Front-to-back queue and output queue sizes (powers of two)
	localparam int IQ_DEPTH = 4;
	localparam int IQ_AW    = $clog2(IQ_DEPTH);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	// Decoded item
	typedef struct packed {
		op_t         op;
		cls_t        cls;
		logic [2:0]  rd;
		logic [2:0]  ra;
		logic [2:0]  rb;
		logic [31:0] imm;
	} dec_t;

	// Head of the front queue as seen by the back end
	typedef struct packed {
		logic valid;
		dec_t item;
	} iq_head_t;

	// Back end status toward the front end
	typedef struct packed {
		logic take;
		logic clearing;
	} bk_stat_t;

	// Result item
	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_write;
		logic [2:0]  reg_index;
		logic [31:0] reg_value;
		logic        mem_write;
		logic [31:0] mem_address;
		logic [31:0] mem_data;
		logic        invalid_halt;
	} res_t;

endpackage

// ----- design/sie_ram.sv -----
// ----------------------------------------------------------------------------
// sie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/sie_front.sv -----
// ----------------------------------------------------------------------------
// sie_front
// Front end: accepts items, classifies the opcode and holds decoded items
// in a short queue for the back end.
// ----------------------------------------------------------------------------
module sie_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [4:0]        opcode,
	input  logic [2:0]        dest_reg,
	input  logic [2:0]        src_a_reg,
	input  logic [2:0]        src_b_reg,
	input  logic [31:0]       immediate,
	input  sie_pkg::bk_stat_t stat,
	output sie_pkg::iq_head_t head
);
	import sie_pkg::*;

	dec_t             q_q [IQ_DEPTH];
	logic [IQ_AW-1:0] wr_ptr_q;
	logic [IQ_AW-1:0] rd_ptr_q;
	logic [IQ_AW:0]   cnt_q;
	logic             accept;
	cls_t             cls;
	dec_t             dec;

	// classify the opcode
	always_comb begin
		unique case (op_t'(opcode)) inside
			OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOT: cls = CL_ALU;
			OP_LOAD:                                       cls = CL_LOAD;
			OP_STORE:                                      cls = CL_STORE;
			OP_JUMP, OP_BRANCH, OP_BEQ, OP_BNE, OP_BLT, OP_BGT:
				cls = CL_BRANCH;
			OP_CMP:                                        cls = CL_CMP;
			OP_LOADI, OP_LOADI16, OP_LOADI16H:             cls = CL_IMM;
			OP_CALL:                                       cls = CL_CALL;
			default:                                       cls = CL_INVALID;
		endcase
	end

	assign dec = '{op: op_t'(opcode), cls: cls, rd: dest_reg, ra: src_a_reg,
		rb: src_b_reg, imm: immediate};

	// no items during the memory clearing pass
	assign full   = (cnt_q == (IQ_AW+1)'(IQ_DEPTH)) || stat.clearing;
	assign accept = push && !full;

	// queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			q_q[wr_ptr_q] <= dec;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (stat.take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (IQ_AW+1)'(accept) - (IQ_AW+1)'(stat.take);
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.item  = q_q[rd_ptr_q];

endmodule

// ----- design/sie_back.sv -----
// ----------------------------------------------------------------------------
// sie_back
// Back end: execute stage (operand forwarding, ALU, branch, flags, pc, store)
// and writeback stage (load data, register write, result to output queue).
// Also runs the clearing pass over data memory and registers after reset.
// ----------------------------------------------------------------------------
module sie_back #(
	parameter int MEM_WORDS = 4096,
	localparam int AW = $clog2(MEM_WORDS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sie_pkg::iq_head_t           head,
	output sie_pkg::bk_stat_t           stat,
	input  logic [sie_pkg::OQ_AW:0]     oq_cnt,
	output logic                        wb_push,
	output sie_pkg::res_t               wb_res
);
	import sie_pkg::*;

	// clearing pass
	logic          clearing_q;
	logic [AW-1:0] clr_idx_q;

	// architectural state
	logic [31:0] pc_q;
	logic        z_q;
	logic        n_q;
	logic        cmp_done_q;
	logic        halted_q;

	// pipeline
	logic        e_valid_s1;
	dec_t        e_item_s1;
	logic        w_valid_s2;
	res_t        w_res_s2;
	logic        w_load_s2;
	logic        w_ldok_s2;
	logic        take;
	logic        e_go;

	// register file ports
	logic [2:0]  rf_ra_addr, rf_rb_addr, rf_rd_addr;
	logic [31:0] rf_ra, rf_rb, rf_rd;
	logic        rf_we;
	logic [2:0]  rf_waddr;
	logic [31:0] rf_wdata;
	logic        lw_valid_q;
	logic [2:0]  lw_idx_q;
	logic [31:0] lw_val_q;

	// data memory ports
	logic          dm_we;
	logic [AW-1:0] dm_waddr;
	logic [31:0]   dm_rdata;

	// execute signals
	logic [31:0]   ra_f, rb_f, rd_f;
	logic [31:0]   addr;
	logic          in_rng;
	logic [AW-1:0] mem_idx;
	logic          halt_now;
	logic          br_take;
	logic [31:0]   val;
	logic          wr;
	logic [31:0]   w_value;
	res_t          res;

	// ------------------------------------------------------------------
	// issue control
	// ------------------------------------------------------------------
	assign e_go = e_valid_s1 &&
		(({1'b0, oq_cnt} + (OQ_AW+2)'(w_valid_s2)) < (OQ_AW+2)'(OQ_DEPTH));
	assign take = head.valid && !clearing_q && (!e_valid_s1 || e_go);

	assign stat.take     = take;
	assign stat.clearing = clearing_q;

	// ------------------------------------------------------------------
	// clearing pass over data memory; registers are cleared on the way
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(MEM_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// register file: three read copies, read addresses follow the item
	// that will sit in execute next cycle
	// ------------------------------------------------------------------
	assign rf_ra_addr = take ? head.item.ra : e_item_s1.ra;
	assign rf_rb_addr = take ? head.item.rb : e_item_s1.rb;
	assign rf_rd_addr = take ? head.item.rd : e_item_s1.rd;

	assign w_value  = w_load_s2 ? (w_ldok_s2 ? dm_rdata : '0) : w_res_s2.reg_value;
	assign rf_we    = clearing_q || (w_valid_s2 && w_res_s2.reg_write);
	assign rf_waddr = clearing_q ? clr_idx_q[2:0] : w_res_s2.reg_index;
	assign rf_wdata = clearing_q ? '0 : w_value;

	sie_ram #(.WIDTH(32), .DEPTH(8)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_ra_addr), .rdata(rf_ra)
	);
	sie_ram #(.WIDTH(32), .DEPTH(8)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_rb_addr), .rdata(rf_rb)
	);
	sie_ram #(.WIDTH(32), .DEPTH(8)) u_rf_d (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_rd_addr), .rdata(rf_rd)
	);

	// write committed at the last edge, missed by the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else begin
			lw_valid_q <= rf_we;
		end
	end

	always_ff @(posedge clk) begin
		lw_idx_q <= rf_waddr;
		lw_val_q <= rf_wdata;
	end

	// operand forwarding: writeback first, then last write, then array
	function automatic logic [31:0] fwd(input logic [2:0] idx, input logic [31:0] arr,
			input logic w_hit, input logic [2:0] w_idx, input logic [31:0] w_val,
			input logic l_hit, input logic [2:0] l_idx, input logic [31:0] l_val);
		logic [31:0] r;
		if (w_hit && idx == w_idx) begin
			r = w_val;
		end else if (l_hit && idx == l_idx) begin
			r = l_val;
		end else begin
			r = arr;
		end
		return r;
	endfunction

	assign ra_f = fwd(e_item_s1.ra, rf_ra, w_valid_s2 && w_res_s2.reg_write,
		w_res_s2.reg_index, w_value, lw_valid_q, lw_idx_q, lw_val_q);
	assign rb_f = fwd(e_item_s1.rb, rf_rb, w_valid_s2 && w_res_s2.reg_write,
		w_res_s2.reg_index, w_value, lw_valid_q, lw_idx_q, lw_val_q);
	assign rd_f = fwd(e_item_s1.rd, rf_rd, w_valid_s2 && w_res_s2.reg_write,
		w_res_s2.reg_index, w_value, lw_valid_q, lw_idx_q, lw_val_q);

	// ------------------------------------------------------------------
	// data memory
	// ------------------------------------------------------------------
	assign addr    = rb_f + e_item_s1.imm;
	assign in_rng  = addr[31:2] < 30'(MEM_WORDS);
	assign mem_idx = addr[AW+1:2];

	assign dm_we    = clearing_q ||
		(e_go && !halt_now && e_item_s1.cls == CL_STORE && in_rng);
	assign dm_waddr = clearing_q ? clr_idx_q : mem_idx;

	sie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
		.clk(clk), .we(dm_we), .waddr(dm_waddr),
		.wdata(clearing_q ? 32'd0 : rd_f),
		.raddr(mem_idx), .rdata(dm_rdata)
	);

	// ------------------------------------------------------------------
	// execute
	// ------------------------------------------------------------------
	assign halt_now = halted_q || (e_item_s1.cls == CL_INVALID);

	// branch condition
	always_comb begin
		unique case (e_item_s1.op)
			OP_JUMP:   br_take = 1'b1;
			OP_BRANCH: br_take = (rb_f == '0);
			OP_BEQ:    br_take = cmp_done_q ? z_q : (rb_f == '0);
			OP_BNE:    br_take = cmp_done_q ? !z_q : (rb_f != '0);
			OP_BLT:    br_take = cmp_done_q ? n_q : ((rb_f & SIGN_MASK) != '0);
			OP_BGT:    br_take = cmp_done_q ? (!n_q && !z_q) : ((rb_f & SIGN_MASK) == '0);
			default:   br_take = 1'b0;
		endcase
	end

	// register result
	always_comb begin
		wr  = 1'b1;
		val = '0;
		unique case (e_item_s1.op)
			OP_ADD:      val = ra_f + rb_f;
			OP_SUB:      val = ra_f - rb_f;
			OP_AND:      val = ra_f & rb_f;
			OP_OR:       val = ra_f | rb_f;
			OP_XOR:      val = ra_f ^ rb_f;
			OP_NOT:      val = ~ra_f;
			OP_LOAD:     val = '0;
			OP_LOADI:    val = e_item_s1.imm;
			OP_LOADI16:  val = (rd_f & HI_MASK) | (e_item_s1.imm & LO_MASK);
			OP_LOADI16H: val = (rd_f & LO_MASK) | {e_item_s1.imm[15:0], 16'h0000};
			default:     wr = 1'b0;
		endcase
		if (halt_now) begin
			wr = 1'b0;
		end
	end

	// result item
	always_comb begin
		res              = '0;
		res.invalid_halt = halt_now;
		if (halt_now) begin
			res.next_pc = pc_q;
		end else begin
			if (e_item_s1.cls == CL_CALL) begin
				res.next_pc = rd_f;
			end else begin
				res.next_pc = pc_q + (br_take ? e_item_s1.imm : 32'd0) + PC_STEP;
			end
			res.reg_write = wr;
			res.reg_index = wr ? e_item_s1.rd : 3'd0;
			res.reg_value = wr ? val : 32'd0;
			if (e_item_s1.cls == CL_STORE) begin
				res.mem_write   = 1'b1;
				res.mem_address = addr;
				res.mem_data    = rd_f;
			end
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_valid_s1 <= 1'b0;
			w_valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				e_valid_s1 <= 1'b1;
			end else if (e_go) begin
				e_valid_s1 <= 1'b0;
			end
			w_valid_s2 <= e_go;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (take) begin
			e_item_s1 <= head.item;
		end
		if (e_go) begin
			w_res_s2  <= res;
			w_load_s2 <= !halt_now && (e_item_s1.cls == CL_LOAD);
			w_ldok_s2 <= in_rng;
		end
	end

	// machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= '0;
			z_q        <= 1'b0;
			n_q        <= 1'b0;
			cmp_done_q <= 1'b0;
			halted_q   <= 1'b0;
		end else if (e_go) begin
			pc_q <= res.next_pc;
			if (e_item_s1.cls == CL_INVALID) begin
				halted_q <= 1'b1;
			end
			if (!halt_now && e_item_s1.cls == CL_CMP) begin
				z_q        <= (ra_f == rb_f);
				n_q        <= ($signed(ra_f) < $signed(rb_f));
				cmp_done_q <= 1'b1;
			end
		end
	end

	// writeback toward the output queue
	assign wb_push = w_valid_s2;
	always_comb begin
		wb_res           = w_res_s2;
		wb_res.reg_value = w_value;
	end

`ifndef ASSERT_OFF
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !e_valid_s1 && !w_valid_s2)
		else $error("item in flight during memory clearing");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt released without reset");
	a_wb_room: assert property (@(posedge clk) disable iff (!arst_n)
		w_valid_s2 |-> ({1'b0, oq_cnt} < (OQ_AW+2)'(OQ_DEPTH)))
		else $error("writeback without output queue room");
`endif

endmodule

// ----- design/sie_outq.sv -----
// ----------------------------------------------------------------------------
// sie_outq
// Output queue of result items; the back end reserves room before issue.
// ----------------------------------------------------------------------------
module sie_outq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  sie_pkg::res_t           din,
	input  logic                    pop,
	output logic                    empty,
	output sie_pkg::res_t           dout,
	output logic [sie_pkg::OQ_AW:0] cnt
);
	import sie_pkg::*;

	res_t             q_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_AW:0]   cnt_q;
	logic             deq;

	assign empty = (cnt_q == '0);
	assign deq   = pop && !empty;
	assign dout  = q_q[rd_ptr_q];
	assign cnt   = cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= din;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (OQ_AW+1)'(push) - (OQ_AW+1)'(deq);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != (OQ_AW+1)'(OQ_DEPTH)) || deq)
		else $error("output queue overflow");
`endif

endmodule

// ----- design/small_risc_instruction_execute.sv -----
// ----------------------------------------------------------------------------
// small_risc_instruction_execute
// Executes one decoded instruction of a small 32-bit machine per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel is a queue write side: an item (opcode, registers,
//   immediate) is taken on a clock edge with push high and full low.
//   Result channel is a queue read side: while empty is low the oldest
//   result is on the result ports; it is taken on an edge with pop high.
//   Every item yields exactly one result, in order.
//   A taken item passes the front queue, execute and writeback, then its
//   result enters the output queue. Throughput: one item per cycle when
//   not stalled, including load-use and compare-branch chains; results
//   are forwarded from writeback and the register write port.
//   Reset: registers, pc, flags and halt go to zero; afterwards a clearing
//   pass writes zero to every data memory word, with full held high.
//   Stall: when pop is held low the output queue (4 items) fills, execute
//   holds, the front queue (4 items) fills and full rises.
// ----------------------------------------------------------------------------
module small_risc_instruction_execute #(
	parameter int MEM_WORDS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [4:0]  opcode,
	input  logic [2:0]  dest_reg,
	input  logic [2:0]  src_a_reg,
	input  logic [2:0]  src_b_reg,
	input  logic [31:0] immediate,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] next_pc,
	output logic        reg_write,
	output logic [2:0]  reg_index,
	output logic [31:0] reg_value,
	output logic        mem_write,
	output logic [31:0] mem_address,
	output logic [31:0] mem_data,
	output logic        invalid_halt
);
	import sie_pkg::*;

	iq_head_t       head;
	bk_stat_t       stat;
	logic           wb_push;
	res_t           wb_res;
	res_t           out_res;
	logic [OQ_AW:0] oq_cnt;

	// front end: accept and classify
	sie_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.opcode(opcode), .dest_reg(dest_reg), .src_a_reg(src_a_reg),
		.src_b_reg(src_b_reg), .immediate(immediate),
		.stat(stat), .head(head)
	);

	// back end: execute and writeback
	sie_back #(.MEM_WORDS(MEM_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .stat(stat),
		.oq_cnt(oq_cnt), .wb_push(wb_push), .wb_res(wb_res)
	);

	// result queue
	sie_outq u_outq (
		.clk(clk), .arst_n(arst_n), .push(wb_push), .din(wb_res),
		.pop(pop), .empty(empty), .dout(out_res), .cnt(oq_cnt)
	);

	assign next_pc      = out_res.next_pc;
	assign reg_write    = out_res.reg_write;
	assign reg_index    = out_res.reg_index;
	assign reg_value    = out_res.reg_value;
	assign mem_write    = out_res.mem_write;
	assign mem_address  = out_res.mem_address;
	assign mem_data     = out_res.mem_data;
	assign invalid_halt = out_res.invalid_halt;

endmodule
